FILE: rtl/core/pesx_pkg.sv
// Shared types, constants and helpers for the PES header timestamp extractor.
package pesx_pkg;

    localparam int HDR_LEN = 19;
    localparam int POS_W   = $clog2(HDR_LEN + 1);

    localparam logic [POS_W-1:0] POS_FULL = POS_W'(HDR_LEN);

    // Stream ids that carry no optional PES header
    localparam logic [7:0] SID_PROG_MAP   = 8'hBC;
    localparam logic [7:0] SID_PADDING    = 8'hBE;
    localparam logic [7:0] SID_PRIVATE_2  = 8'hBF;
    localparam logic [7:0] SID_ECM        = 8'hF0;
    localparam logic [7:0] SID_EMM        = 8'hF1;
    localparam logic [7:0] SID_DSMCC      = 8'hF2;
    localparam logic [7:0] SID_H222_E     = 8'hF8;
    localparam logic [7:0] SID_PROG_DIR   = 8'hFF;

    localparam logic [1:0] FLAGS_PTS      = 2'b10;
    localparam logic [1:0] FLAGS_PTS_DTS  = 2'b11;

    // Header bytes, index = position in the payload
    typedef logic [HDR_LEN-1:0][7:0] t_hdr;

    typedef struct packed {
        logic        header_found;
        logic [7:0]  stream_kind;
        logic [15:0] packet_length;
        logic [1:0]  stamp_flags;
        logic [31:0] presentation_stamp;
        logic [31:0] decoding_stamp;
    } t_result;

    // Bits 32..1 of a 33-bit stamp spread over five bytes with marker bits
    function automatic logic [31:0] stamp_at(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [7:0] b4);
        return {b0[3:1], b1, b2[7:1], b3, b4[7:2]};
    endfunction

endpackage

FILE: rtl/core/pesx_cell.sv
// One byte cell of the header shift chain.
module pesx_cell
    import pesx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte,
    output logic [7:0] o_next
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    assign n_byte = i_shift ? i_byte : r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_next = n_byte;

endmodule

FILE: rtl/core/pesx_decode.sv
// Field decode of a complete 19-byte PES header.
module pesx_decode
    import pesx_pkg::*;
(
    input  t_hdr    i_hdr,
    input  logic    i_full,
    output t_result o_result
);

    logic       start_ok;
    logic       plain;
    logic [1:0] flags;

    assign start_ok = i_full && (i_hdr[0] == 8'h00) && (i_hdr[1] == 8'h00)
                      && (i_hdr[2] == 8'h01);

    always_comb begin
        unique case (i_hdr[3]) inside
            SID_PROG_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
            SID_EMM, SID_DSMCC, SID_H222_E, SID_PROG_DIR: plain = 1'b1;
            default: plain = 1'b0;
        endcase
    end

    assign flags = plain ? 2'b00 : i_hdr[7][7:6];

    always_comb begin
        o_result = '0;
        if (start_ok) begin
            o_result.header_found  = 1'b1;
            o_result.stream_kind   = i_hdr[3];
            o_result.packet_length = {i_hdr[4], i_hdr[5]};
            o_result.stamp_flags   = flags;
            if (flags == FLAGS_PTS || flags == FLAGS_PTS_DTS) begin
                o_result.presentation_stamp =
                    stamp_at(i_hdr[9], i_hdr[10], i_hdr[11], i_hdr[12], i_hdr[13]);
            end
            if (flags == FLAGS_PTS_DTS) begin
                o_result.decoding_stamp =
                    stamp_at(i_hdr[14], i_hdr[15], i_hdr[16], i_hdr[17], i_hdr[18]);
            end
        end
    end

endmodule

FILE: rtl/core/pes_header_timestamp_extractor.sv
// Top level: PES header capture chain, decode and output register.
//
// Takes one PES payload byte per request, marked first and last, and on the
// request carrying the last byte produces one result with the start-code
// check, stream id, packet length, PTS/DTS flags and both stamps as bits
// 32..1 (45 kHz count). Throughput is one byte per cycle unless stalled; the
// result of a payload appears in the output register the cycle after its
// last byte is taken. The first 19 bytes of a payload shift through a chain
// of 19 byte cells; a 5-bit counter tracks how many are held and freezes the
// chain once it is full, so later bytes are ignored. A first mark restarts
// the count, and the count also restarts after every last byte, so a byte
// with no first mark after a result opens a new payload. Payloads shorter
// than 19 bytes or without the 00 00 01 prefix give header_found = 0 with
// every other field 0; stamps not announced by the flags read 0. The input
// stays ready while the output register is empty or being drained.
module pes_header_timestamp_extractor
    import pesx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_header_found,
    output logic [7:0]  o_stream_kind,
    output logic [15:0] o_packet_length,
    output logic [1:0]  o_stamp_flags,
    output logic [31:0] o_presentation_stamp,
    output logic [31:0] o_decoding_stamp
);

    logic             accept;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_after;
    logic             store;
    logic             shift;

    // Cell k holds payload byte (count-1-k); cell 0 takes the newest byte
    logic [HDR_LEN-1:0][7:0] cell_q;
    logic [HDR_LEN-1:0][7:0] cell_n;
    t_hdr                    hdr;

    t_result          dec_result;
    t_result          r_result;
    logic             r_out_valid;
    logic             n_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_base  = i_first_byte ? '0 : r_pos;
    assign store     = pos_base < POS_FULL;
    assign shift     = accept && store;
    assign pos_after = pos_base + POS_W'(store);

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = i_last_byte ? '0 : pos_after;
        end
    end

    genvar k;
    generate
        for (k = 0; k < HDR_LEN; k++) begin : g_cell
            if (k == 0) begin : g_head
                pesx_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_byte (i_payload_byte),
                    .o_byte (cell_q[k]),
                    .o_next (cell_n[k])
                );
            end else begin : g_link
                pesx_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_byte (cell_q[k-1]),
                    .o_byte (cell_q[k]),
                    .o_next (cell_n[k])
                );
            end
            // Valid only when the chain is full, which is all decode relies on
            assign hdr[k] = cell_n[HDR_LEN-1-k];
        end
    endgenerate

    pesx_decode u_decode (
        .i_hdr   (hdr),
        .i_full  (pos_after == POS_FULL),
        .o_result(dec_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept && i_last_byte) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_header_found       = r_result.header_found;
    assign o_stream_kind        = r_result.stream_kind;
    assign o_packet_length      = r_result.packet_length;
    assign o_stamp_flags        = r_result.stamp_flags;
    assign o_presentation_stamp = r_result.presentation_stamp;
    assign o_decoding_stamp     = r_result.decoding_stamp;

endmodule

FILE: rtl/core/pesx_checker.sv
// Port-level checks for the PES header timestamp extractor, bound to the top.
module pesx_checker
    import pesx_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_first_byte,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_header_found,
    input logic [7:0]  o_stream_kind,
    input logic [15:0] o_packet_length,
    input logic [1:0]  o_stamp_flags,
    input logic [31:0] o_presentation_stamp,
    input logic [31:0] o_decoding_stamp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output register");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_first_byte && i_last_byte
        |=> o_out_valid && !o_header_found)
        else $error("single-byte payload not reported as short");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_header_found |->
        o_stream_kind == '0 && o_packet_length == '0 && o_stamp_flags == '0
        && o_presentation_stamp == '0 && o_decoding_stamp == '0)
        else $error("fields not cleared without header");

    a_stamps_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stamp_flags != FLAGS_PTS && o_stamp_flags != FLAGS_PTS_DTS
        |-> o_presentation_stamp == '0 && o_decoding_stamp == '0)
        else $error("stamp reported without flag");

endmodule

bind pes_header_timestamp_extractor pesx_checker u_pesx_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .i_first_byte        (i_first_byte),
    .i_last_byte         (i_last_byte),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_header_found      (o_header_found),
    .o_stream_kind       (o_stream_kind),
    .o_packet_length     (o_packet_length),
    .o_stamp_flags       (o_stamp_flags),
    .o_presentation_stamp(o_presentation_stamp),
    .o_decoding_stamp    (o_decoding_stamp)
);
